### hdl/lpse_pkg.sv
// lpse_pkg: shared types, constants and the line-code function of the led pixel encoder
// no dependencies

package lpse_pkg;

  localparam int RESET_BYTES = 16;
  localparam int MAX_LEDS    = 256;
  localparam int DATA_BYTES  = 9;
  localparam int CODE_W      = DATA_BYTES * 8;
  localparam int POS_W       = 8;
  localparam int COUNT_W     = 9;
  localparam int CNT_W       = $clog2((RESET_BYTES > DATA_BYTES) ? RESET_BYTES : DATA_BYTES);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int PADDR_W     = 3;

  localparam logic [COUNT_W-1:0] MAX_LEDS_C = COUNT_W'(MAX_LEDS);

  // register index of led_count
  localparam logic REG_LED_COUNT = 1'b0;

  // one pixel job handed from front to back
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              lead;
    logic              trail;
  } job_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEAD,
    PH_DATA,
    PH_TRAIL
  } phase_t;

  // green, red, blue msb first; one bit -> 110, zero bit -> 100
  function automatic logic [CODE_W-1:0] line_code(input logic [7:0] green,
                                                  input logic [7:0] red,
                                                  input logic [7:0] blue);
    logic [23:0] bits;
    logic [CODE_W-1:0] code;
    bits = {green, red, blue};
    code = '0;
    for (int i = 0; i < 24; i++) begin
      code[3*i +: 3] = bits[i] ? 3'b110 : 3'b100;
    end
    return code;
  endfunction

endpackage

### hdl/lpse_if.sv
// lpse_if: valid/ready channel interfaces for pixels in and spi bytes out
// depends on nothing

interface lpse_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] green;
  logic [7:0] red;
  logic [7:0] blue;
  modport source (output valid, output green, output red, output blue, input ready);
  modport sink (input valid, input green, input red, input blue, output ready);
endinterface

interface lpse_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] spi_byte;
  logic       run_last;
  logic       frame_end;
  modport source (output valid, output spi_byte, output run_last, output frame_end,
                  input ready);
  modport sink (input valid, input spi_byte, input run_last, input frame_end,
                output ready);
endinterface

### hdl/lpse_front.sv
// lpse_front: accepts pixels, tracks frame position, builds the line code job
// depends on lpse_pkg, lpse_if

module lpse_front
  import lpse_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  lpse_pix_if.sink           pixel,
  input  logic [COUNT_W-1:0] led_count,
  output logic               push_valid,
  output job_t               push_job,
  input  logic               push_ready
);

  logic [POS_W-1:0]   pixel_position;
  logic [POS_W-1:0]   pixel_position_next;
  logic [COUNT_W-1:0] count_eff;
  logic               drop;
  logic               is_first;
  logic               is_last;
  logic               accept;

  always_comb begin
    count_eff = (led_count > MAX_LEDS_C) ? MAX_LEDS_C : led_count;
    drop      = (count_eff == '0);
    is_first  = (pixel_position == '0);
    is_last   = ({1'b0, pixel_position} >= (count_eff - COUNT_W'(1)));
  end

  assign pixel.ready = push_ready;
  assign accept      = pixel.valid && push_ready;
  assign push_valid  = accept && !drop;

  always_comb begin
    push_job.code  = line_code(pixel.green, pixel.red, pixel.blue);
    push_job.lead  = is_first;
    push_job.trail = is_last;
  end

  always_comb begin
    pixel_position_next = pixel_position;
    if (accept) begin
      if (drop || is_last) begin
        pixel_position_next = '0;
      end else begin
        pixel_position_next = pixel_position + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_position <= '0;
    end else begin
      pixel_position <= pixel_position_next;
    end
  end

endmodule

### hdl/lpse_queue.sv
// lpse_queue: short job queue between front and back
// depends on lpse_pkg

module lpse_queue
  import lpse_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  job_t push_job,
  output logic push_ready,
  output logic head_valid,
  output job_t head_job,
  input  logic pop
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

### hdl/lpse_back.sv
// lpse_back: byte sequencer emitting leading reset, data and trailing reset bytes
// depends on lpse_pkg, lpse_if

module lpse_back
  import lpse_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  job_t      head_job,
  output logic      pop,
  lpse_byte_if.source stream
);

  phase_t            phase;
  phase_t            phase_next;
  logic [CNT_W-1:0]  cnt;
  logic [CODE_W-1:0] code;
  logic              trail;
  logic              advance;
  logic              emit;
  logic              job_done;
  logic              cnt_wrap;
  logic [7:0]        byte_val;
  logic              last_val;
  logic              fend_val;
  logic              load;

  logic              out_valid;
  logic [7:0]        out_byte;
  logic              out_last;
  logic              out_fend;

  assign advance = !out_valid || stream.ready;

  // outputs of the sequencer
  always_comb begin
    emit     = 1'b0;
    job_done = 1'b0;
    cnt_wrap = 1'b0;
    byte_val = '0;
    last_val = 1'b0;
    fend_val = 1'b0;
    case (phase)
      PH_LEAD: begin
        emit     = advance;
        cnt_wrap = (cnt == CNT_W'(RESET_BYTES - 1));
      end
      PH_DATA: begin
        emit     = advance;
        byte_val = code[CODE_W-1 -: 8];
        cnt_wrap = (cnt == CNT_W'(DATA_BYTES - 1));
        job_done = advance && cnt_wrap && !trail;
        last_val = cnt_wrap && !trail;
      end
      PH_TRAIL: begin
        emit     = advance;
        cnt_wrap = (cnt == CNT_W'(RESET_BYTES - 1));
        job_done = advance && cnt_wrap;
        last_val = cnt_wrap;
        fend_val = cnt_wrap;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    load = head_valid && ((phase == PH_IDLE) || job_done);
  end

  assign pop = load;

  // next phase
  always_comb begin
    phase_next = phase;
    if (load) begin
      phase_next = head_job.lead ? PH_LEAD : PH_DATA;
    end else if (job_done) begin
      phase_next = PH_IDLE;
    end else if (emit && cnt_wrap) begin
      case (phase)
        PH_LEAD: phase_next = PH_DATA;
        PH_DATA: phase_next = PH_TRAIL;
        default: phase_next = phase;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code  <= head_job.code;
      trail <= head_job.trail;
      cnt   <= '0;
    end else if (emit) begin
      cnt <= cnt_wrap ? '0 : cnt + CNT_W'(1);
      if (phase == PH_DATA) begin
        code <= {code[CODE_W-9:0], 8'h00};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= byte_val;
      out_last <= last_val;
      out_fend <= fend_val;
    end
  end

  assign stream.valid     = out_valid;
  assign stream.spi_byte  = out_byte;
  assign stream.run_last  = out_last;
  assign stream.frame_end = out_fend;

endmodule

### hdl/led_pixel_spi_encoder_top.sv
// led_pixel_spi_encoder_top: pixel to spi line-code encoder with apb register port
// depends on lpse_pkg, lpse_if, lpse_front, lpse_queue, lpse_back

// Each accepted pixel (green, red, blue) becomes nine spi bytes, one bit of
// colour expanded to the three line bits 110 or 100, sent msb first. The first
// pixel of a frame is preceded by 16 zero bytes, and a pixel at or past position
// led_count-1 (led_count capped at 256) is followed by 16 zero bytes, the last
// of them flagged frame_end. run_last marks the last byte caused by a pixel.
// With led_count zero pixels are taken and dropped. Bytes come out one per
// cycle while jobs wait and the receiver keeps taking them; the byte sequencer
// in the back part sets that rate. The front takes a new pixel whenever the
// two-entry job queue has room, so it keeps working while a byte waits in the
// output register. led_count sits at byte address 0 and may be written only
// while the block is idle.

module led_pixel_spi_encoder_top
  import lpse_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  lpse_pix_if.sink           pixel,
  lpse_byte_if.source        stream
);

  logic [COUNT_W-1:0] led_count;
  logic               cfg_write;
  logic               sel_led_count;

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic head_valid;
  job_t head_job;
  logic pop;

  // register decode: word index is paddr[2]
  assign pready        = 1'b1;
  assign sel_led_count = (paddr[2] == REG_LED_COUNT);
  assign cfg_write     = psel && penable && pwrite && sel_led_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count <= '0;
    end else if (cfg_write) begin
      led_count <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = sel_led_count ? {{(32-COUNT_W){1'b0}}, led_count} : '0;

  // front: position tracking and line coding
  lpse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .led_count  (led_count),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  // job queue decouples front and back
  lpse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  // back: one byte per cycle into the output register while it is empty or being taken
  lpse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .stream     (stream)
  );

endmodule

### tb/sv/testbench.sv
// testbench: self-checking bench for led_pixel_spi_encoder_top, pixels in, spi bytes out
// depends on lpse_pkg, lpse_if and the encoder rtl; a directed table, then random frames

`timescale 1ns / 100ps

module testbench;
  import lpse_pkg::*;

  localparam int PERIOD        = 20;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 40;    // let a dropped pixel clear before a register write
  localparam int TAIL_CYCLES   = 64;    // quiet time at the end for stray bytes
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off, fills the job queue
  localparam int STALL_LIMIT   = 4000;  // cycles with no handshake on either channel
  localparam int RANDOM_PIXELS = 245;
  localparam int NUM_ROWS      = 21;

  // register map: index times four
  localparam logic [PADDR_W-1:0] LED_COUNT_ADDR = PADDR_W'(4 * int'(REG_LED_COUNT));
  localparam logic [PADDR_W-1:0] UNUSED_ADDR    = PADDR_W'(4);

  // line code of a colour byte of all ones and of all zeros
  localparam logic [23:0] ONE_L   = 24'hDB6DB6;
  localparam logic [23:0] ZERO_L  = 24'h924924;
  localparam logic [71:0] NO_CODE = 72'h0;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       run_last;
    logic       frame_end;
  } byte_res_t;

  // one row of the directed part; where typed is set, the bytes come from
  // lead, code and trail (none: the pixel is dropped) instead of the predictor
  typedef struct packed {
    logic               wr;
    logic [PADDR_W-1:0] wr_addr;
    logic [31:0]        wr_data;
    logic [7:0]         green;
    logic [7:0]         red;
    logic [7:0]         blue;
    logic               typed;
    logic               none;
    logic               lead;
    logic               trail;
    logic [71:0]        code;
  } pixel_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  lpse_pix_if  pix_ch ();
  lpse_byte_if byte_ch ();

  led_pixel_spi_encoder_top DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pixel   (pix_ch),
    .stream  (byte_ch)
  );

  always #(PERIOD / 2) clk = ~clk;

  // encoder shadow state: register copy and position within the frame
  logic [COUNT_W-1:0] leds_per_frame;
  logic [POS_W-1:0]   frame_pos;

  // spi bytes still owed by the encoder, oldest first
  byte_res_t line_bytes[$];
  byte_res_t want;

  int mismatches    = 0;
  int stall_cycles  = 0;
  int src_idle_pct  = 28;
  int sink_idle_pct = 49;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  // directed part: reset state, line-code extremes, single-pixel frames,
  // count dropped to zero mid-frame, count lowered under the position,
  // counts above the led limit, upper write bits ignored, unknown register
  pixel_row_t directed_rows [NUM_ROWS] = '{
    // led_count zero after reset: pixel swallowed
    '{1'b0, LED_COUNT_ADDR, 32'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, NO_CODE},
    // one-pixel frames get both reset runs
    '{1'b1, LED_COUNT_ADDR, 32'd1, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1,
      {ZERO_L, ZERO_L, ZERO_L}},
    '{1'b0, LED_COUNT_ADDR, 32'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b1,
      {ONE_L, ONE_L, ONE_L}},
    // three-pixel frame: lead only, plain, trail only
    '{1'b1, LED_COUNT_ADDR, 32'd3, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0,
      {ONE_L, ZERO_L, ONE_L}},
    '{1'b0, LED_COUNT_ADDR, 32'd0, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0,
      {ZERO_L, ONE_L, ZERO_L}},
    '{1'b0, LED_COUNT_ADDR, 32'd0, 8'h80, 8'h01, 8'hA5, 1'b0, 1'b0, 1'b0, 1'b0, NO_CODE},
    '{1'b0, LED_COUNT_ADDR, 32'd0, 8'h01, 8'h80, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0, NO_CODE},
    // output disabled mid-frame, position falls back to zero
    '{1'b1, LED_COUNT_ADDR, 32'd0, 8'h12, 8'h34, 8'h56, 1'b1, 1'b1, 1'b0, 1'b0, NO_CODE},
    '{1'b1, LED_COUNT_ADDR, 32'd4, 8'hC3, 8'h3C, 8'h0F, 1'b0, 1'b0, 1'b0, 1'b0, NO_CODE},
    '{1'b0, LED_COUNT_ADDR, 32'd0, 8'hF0, 8'h0F, 8'hAA, 1'b0, 1'b0, 1'b0, 1'b0, NO_CODE},
    '{1'b0, LED_COUNT_ADDR, 32'd0, 8'h55, 8'h99, 8'h66, 1'b0, 1'b0, 1'b0, 1'b0, NO_CODE},
    // count lowered under the position: this pixel closes the frame
    '{1'b1, LED_COUNT_ADDR, 32'd2, 8'h81, 8'h42, 8'h24, 1'b0, 1'b0, 1'b0, 1'b0, NO_CODE},
    // all-ones count pattern, clamped to the led limit
    '{1'b1, LED_COUNT_ADDR, 32'h1FF, 8'h00, 8'hFF, 8'h80, 1'b0, 1'b0, 1'b0, 1'b0, NO_CODE},
    '{1'b0, LED_COUNT_ADDR, 32'd0, 8'h01, 8'h02, 8'h04, 1'b0, 1'b0, 1'b0, 1'b0, NO_CODE},
    '{1'b0, LED_COUNT_ADDR, 32'd0, 8'hFE, 8'hFD, 8'hFB, 1'b0, 1'b0, 1'b0, 1'b0, NO_CODE},
    '{1'b0, LED_COUNT_ADDR, 32'd0, 8'h7E, 8'hE7, 8'h18, 1'b0, 1'b0, 1'b0, 1'b0, NO_CODE},
    '{1'b1, LED_COUNT_ADDR, 32'd1, 8'h3C, 8'hC3, 8'h99, 1'b0, 1'b0, 1'b0, 1'b0, NO_CODE},
    // exactly the led limit
    '{1'b1, LED_COUNT_ADDR, 32'd256, 8'h55, 8'hAA, 8'hC3, 1'b0, 1'b0, 1'b0, 1'b0, NO_CODE},
    // garbage above the count field is ignored: count two
    '{1'b1, LED_COUNT_ADDR, 32'hFFFF_FE02, 8'hAA, 8'h55, 8'h3C, 1'b0, 1'b0, 1'b0, 1'b0,
      NO_CODE},
    // write to an index with no register: count stays two
    '{1'b1, UNUSED_ADDR, 32'd0, 8'h7F, 8'hFE, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0, NO_CODE},
    '{1'b0, LED_COUNT_ADDR, 32'd0, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, NO_CODE}
  };

  // 110 for a one, 100 for a zero, msb first
  function automatic logic [23:0] colour_line_bits(input logic [7:0] colour);
    logic [23:0] bits;
    int i;
    bits = '0;
    for (i = 7; i >= 0; i--) begin
      bits = {bits[20:0], colour[i] ? 3'b110 : 3'b100};
    end
    return bits;
  endfunction

  // queue the bytes of one pixel: optional leading zeros, nine code bytes,
  // optional trailing zeros with frame_end on the last one
  task automatic queue_pixel_bytes(input logic lead, input logic [71:0] code,
                                   input logic trail);
    byte_res_t res;
    int k;
    res = '0;
    if (lead) begin
      for (k = 0; k < RESET_BYTES; k++) line_bytes.push_back(res);
    end
    for (k = 0; k < DATA_BYTES; k++) begin
      res.spi_byte = code[71 - 8 * k -: 8];
      line_bytes.push_back(res);
    end
    if (trail) begin
      res.spi_byte = 8'h00;
      for (k = 0; k < RESET_BYTES; k++) begin
        res.frame_end = (k == RESET_BYTES - 1);
        line_bytes.push_back(res);
      end
    end
    line_bytes[line_bytes.size() - 1].run_last = 1'b1;
  endtask

  // advance the frame position for one accepted pixel and, unless the row
  // types its bytes in, queue what the encoder owes for it
  task automatic predict_pixel_bytes(input logic [7:0] green, input logic [7:0] red,
                                     input logic [7:0] blue, input logic enqueue);
    logic [COUNT_W-1:0] active;
    logic               lead;
    logic               trail;
    active = (leds_per_frame > MAX_LEDS_C) ? MAX_LEDS_C : leds_per_frame;
    if (active == '0) begin
      frame_pos = '0;
    end else begin
      lead  = (frame_pos == '0);
      trail = ({1'b0, frame_pos} >= active - COUNT_W'(1));
      if (enqueue) begin
        queue_pixel_bytes(lead, {colour_line_bits(green), colour_line_bits(red),
                                 colour_line_bits(blue)}, trail);
      end
      frame_pos = trail ? '0 : frame_pos + POS_W'(1);
    end
  endtask

  // one apb transfer: setup cycle, access cycle, done when pready is seen
  task automatic apb_access(input logic is_write, input logic [PADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering pixels and wait until every owed byte has come out
  task automatic drain_bytes();
    pix_ch.valid <= 1'b0;
    do @(posedge clk); while (line_bytes.size() != 0);
  endtask

  // register writes only with the encoder idle; led_count is read back after
  task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    logic [31:0] readback;
    drain_bytes();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_access(1'b1, addr, data, readback);
    if (addr == LED_COUNT_ADDR) leds_per_frame = data[COUNT_W-1:0];
    apb_access(1'b0, LED_COUNT_ADDR, 32'd0, readback);
    if (readback !== 32'(leds_per_frame)) begin
      $error("led_count: expected %0d, got %0d", leds_per_frame, readback);
      mismatches++;
    end
  endtask

  // offer one pixel, with a random idle gap in front; valid stays high
  // after the handshake so the next pixel can follow back to back
  task automatic send_pixel(input logic [7:0] green, input logic [7:0] red,
                            input logic [7:0] blue);
    if ($urandom_range(99) < src_idle_pct) begin
      pix_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.green <= green;
    pix_ch.red   <= red;
    pix_ch.blue  <= blue;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  // colour values lean toward the extremes
  function automatic logic [7:0] pick_intensity();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  // receiver: random ready, or a long hold-off when the stimulus asks for one
  initial begin
    byte_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        byte_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        byte_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // every accepted spi byte against the oldest owed one
  always @(posedge clk) begin
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      if (line_bytes.size() == 0) begin
        $error("spi_byte: nothing expected, got %h", byte_ch.spi_byte);
        mismatches++;
      end else begin
        want = line_bytes.pop_front();
        if (byte_ch.spi_byte !== want.spi_byte) begin
          $error("spi_byte: expected %h, got %h", want.spi_byte, byte_ch.spi_byte);
          mismatches++;
        end
        if (byte_ch.run_last !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, byte_ch.run_last);
          mismatches++;
        end
        if (byte_ch.frame_end !== want.frame_end) begin
          $error("frame_end: expected %b, got %b", want.frame_end, byte_ch.frame_end);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long without a handshake on either channel ends the run
  always @(posedge clk) begin
    if ((pix_ch.valid && pix_ch.ready) || (byte_ch.valid && byte_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus
  initial begin
    logic [31:0]        rnd;
    logic [COUNT_W-1:0] count;
    logic [PADDR_W-1:0] addr;
    int                 kind;
    int                 n;
    int                 lit_pixels;
    logic               held;
    logic               paused;
    lit_pixels     = 0;
    held           = 1'b0;
    paused         = 1'b0;
    leds_per_frame = '0;
    frame_pos      = '0;
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    pix_ch.valid  <= 1'b0;
    pix_ch.green  <= '0;
    pix_ch.red    <= '0;
    pix_ch.blue   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed table, first idling mode
    foreach (directed_rows[i]) begin
      if (directed_rows[i].wr) begin
        write_register(directed_rows[i].wr_addr, directed_rows[i].wr_data);
      end
      send_pixel(directed_rows[i].green, directed_rows[i].red, directed_rows[i].blue);
      predict_pixel_bytes(directed_rows[i].green, directed_rows[i].red,
                          directed_rows[i].blue, !directed_rows[i].typed);
      if (directed_rows[i].typed && !directed_rows[i].none) begin
        queue_pixel_bytes(directed_rows[i].lead, directed_rows[i].code,
                          directed_rows[i].trail);
      end
    end

    // random phases: mostly short frames, now and then a count of zero
    // (pixels swallowed), a count at or above the led limit that a later
    // phase cuts short, or a write to an index with no register
    while (lit_pixels < RANDOM_PIXELS) begin
      kind  = $urandom_range(15);
      addr  = LED_COUNT_ADDR;
      count = leds_per_frame;
      if (kind == 0) begin
        count = '0;
        n     = $urandom_range(1, 3);
      end else if (kind == 1) begin
        count = ($urandom_range(1) == 0) ? COUNT_W'(256) : COUNT_W'($urandom_range(256, 511));
        n     = $urandom_range(2, 12);
      end else if (kind == 2) begin
        addr  = UNUSED_ADDR;
        n     = $urandom_range(1, 10);
      end else begin
        count = COUNT_W'($urandom_range(1, 8));
        n     = $urandom_range(1, 3 * int'(count));
      end
      rnd = $urandom();
      write_register(addr, {rnd[31:COUNT_W], count});

      for (int k = 0; k < n; k++) begin
        // idling: sender light / receiver heavy, then swapped, then none
        if (lit_pixels < RANDOM_PIXELS / 3) begin
          src_idle_pct  = 28;
          sink_idle_pct = 49;
        end else if (lit_pixels < 2 * RANDOM_PIXELS / 3) begin
          src_idle_pct  = 49;
          sink_idle_pct = 28;
        end else begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
        // receiver holds off while pixels keep coming, so the queue fills
        if (!held && lit_pixels >= 40) begin
          hold_requests++;
          held = 1'b1;
        end
        // sender waits for the encoder to run dry
        if (!paused && lit_pixels >= 120) begin
          drain_bytes();
          paused = 1'b1;
        end
        send_pixel(pick_intensity(), pick_intensity(), pick_intensity());
        predict_pixel_bytes(pix_ch.green, pix_ch.red, pix_ch.blue, 1'b1);
        if (leds_per_frame != '0) lit_pixels++;
      end
    end

    drain_bytes();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && line_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
